### rtl/stmcd_pkg.sv
// Shared constants and types for the supply and temperature monitor core.
// Field widths, calibration constants, register indexes and opcodes.
// No dependencies; compile before the core.
`default_nettype none

package stmcd_pkg;

    // Field widths
    localparam int ADC_BITS  = 12;
    localparam int SAMPLE_W  = 12;
    localparam int OPCODE_W  = 2;
    localparam int CAL_W     = 12;
    localparam int PCT_W     = 7;
    localparam int MV_W      = 16;
    localparam int TEMP_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    // Datapath widths
    localparam int QUO_W   = 16;                // quotient bits built by the divider
    localparam int DEN_W   = 24;                // divisor and remainder
    localparam int NUM_W   = DEN_W + QUO_W;     // dividend magnitude
    localparam int PROD_W  = ADC_BITS + MV_W;   // sample times supply
    localparam int MV10_W  = 13;                // millivolts divided by ten
    localparam int CNT_W   = 4;                 // iteration counter

    // Calibration and scaling constants
    localparam int CAL_MV      = 3000;          // calibration supply in mV
    localparam int TEMP_MIN    = -1000;         // tenths of a degree
    localparam int TEMP_MAX    = 2000;
    localparam int TEMP_MID    = 300;           // 30.0 degrees at the low point
    localparam int OFFSET_K    = 900;           // TEMP_MID * CAL_MV / 1000
    localparam int SUPPLY_STEP = 33;            // mV per percent of 3.3 V
    localparam int TEMP_STEP   = 10;            // tenths per percent of 100 degrees
    localparam int DIV10_MUL   = 52429;         // ceil(2^19 / 10)
    localparam int DIV10_SHIFT = 19;

    // Register reset values
    localparam logic [CAL_W-1:0] CAL_VREF_RST       = 12'd1655;
    localparam logic [CAL_W-1:0] CAL_TEMP_LOW_RST   = 12'd1030;
    localparam logic [CAL_W-1:0] CAL_TEMP_HIGH_RST  = 12'd1370;
    localparam logic [PCT_W-1:0] MIN_PCT_SUPPLY_RST = 7'd1;
    localparam logic [PCT_W-1:0] MIN_PCT_TEMP_RST   = 7'd10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_VREF       = 3'd0,
        REG_CAL_TEMP_LOW   = 3'd1,
        REG_CAL_TEMP_HIGH  = 3'd2,
        REG_MIN_PCT_SUPPLY = 3'd3,
        REG_MIN_PCT_TEMP   = 3'd4
    } cfg_reg_t;

    // Input opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_REFERENCE   = 2'd0,
        OP_TEMPERATURE = 2'd1,
        OP_RECORD      = 2'd2,
        OP_HOLD        = 2'd3
    } opcode_t;

endpackage

`default_nettype wire

### rtl/supply_temp_monitor_change_detect_core.sv
// Supply voltage and temperature monitor with change detection.
// Serial multiplier, shared 16-step restoring divider and sequencer.
// Depends on stmcd_pkg.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    tdata: sample; tuser: opcode
//  m_        out        m_tvalid/m_tready    tdata: supply_mv, temp_tenths; tuser: flags
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One beat is worked on at a time. Reference beats run divider load, 16 divider steps,
// scale, commit and output; temperature beats run a 12-step serial multiply and two prep
// steps ahead of the same sequence; record and hold beats run commit and output only.
// A zero reference sample skips the divider and a flat calibration span skips the
// temperature math. The next beat is taken as soon as the result sits in the
// output register, even while m_tready is low; a stalled result holds the
// sequencer in its last step. aresetn is synchronous, active low, and restores the
// calibration defaults and clears the monitor state.
`default_nettype none

module supply_temp_monitor_change_detect_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] supply_mv, [27:16] temp_tenths, [31:28] zero
    output logic [1:0]       m_tuser,   // [0] stable, [1] send_needed
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    localparam int ADC_BITS = stmcd_pkg::ADC_BITS;
    localparam int CAL_W    = stmcd_pkg::CAL_W;
    localparam int PCT_W    = stmcd_pkg::PCT_W;
    localparam int MV_W     = stmcd_pkg::MV_W;
    localparam int TEMP_W   = stmcd_pkg::TEMP_W;
    localparam int QUO_W    = stmcd_pkg::QUO_W;
    localparam int DEN_W    = stmcd_pkg::DEN_W;
    localparam int NUM_W    = stmcd_pkg::NUM_W;
    localparam int PROD_W   = stmcd_pkg::PROD_W;
    localparam int MV10_W   = stmcd_pkg::MV10_W;
    localparam int CNT_W    = stmcd_pkg::CNT_W;
    localparam int E_W      = PROD_W + 2;       // signed scaled numerator
    localparam int VTHR_W   = PCT_W + 6;        // percent times 33
    localparam int TTHR_W   = PCT_W + 4;        // percent times 10

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_NSCL,
        ST_DINIT,
        ST_DIV,
        ST_SCALE,
        ST_COMMIT,
        ST_OUT
    } state_t;

    // Sequencer and datapath registers
    state_t                   state_reg;
    stmcd_pkg::opcode_t       op_reg;
    logic [ADC_BITS-1:0]      smp_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic                     ovf_reg;
    logic                     neg_reg;
    logic [MV_W-1:0]          mv_reg;
    logic [MV10_W-1:0]        mv10_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     stable_reg;

    // Monitor state
    logic [MV_W-1:0]          last_reg;
    logic [MV10_W-1:0]        last10_reg;
    logic [MV_W-1:0]          acc_reg;
    logic signed [TEMP_W-1:0] cur_temp_reg;
    logic [MV_W-1:0]          sent_supply_reg;
    logic signed [TEMP_W-1:0] sent_temp_reg;

    // Configuration registers
    logic [CAL_W-1:0]         cal_vref_reg;
    logic [CAL_W-1:0]         cal_temp_low_reg;
    logic [CAL_W-1:0]         cal_temp_high_reg;
    logic [PCT_W-1:0]         min_pct_supply_reg;
    logic [PCT_W-1:0]         min_pct_temp_reg;

    // Output register
    logic                     m_tvalid_reg;
    logic [MV_W-1:0]          m_supply_reg;
    logic signed [TEMP_W-1:0] m_temp_reg;
    logic                     m_stable_reg;
    logic                     m_send_reg;

    // Input beat fields
    logic [ADC_BITS-1:0]      s_sample;
    stmcd_pkg::opcode_t       s_opcode;
    logic                     s_accept;
    logic                     out_free;

    assign s_sample = s_tdata[ADC_BITS-1:0];
    assign s_opcode = stmcd_pkg::opcode_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Reference numerator: calibration supply times factory reference reading
    logic [DEN_W-1:0] vref_num;
    assign vref_num = DEN_W'(cal_vref_reg) * DEN_W'(stmcd_pkg::CAL_MV);

    // Calibration span and its magnitude
    logic signed [CAL_W:0] span_s;
    logic [CAL_W-1:0]      span_mag;
    assign span_s   = $signed({1'b0, cal_temp_high_reg}) - $signed({1'b0, cal_temp_low_reg});
    assign span_mag = span_s[CAL_W] ? CAL_W'(-span_s) : CAL_W'(span_s);

    // Temperature numerator before the final scale by 1000
    logic [PROD_W-1:0]     low_mv;
    logic signed [PROD_W:0] diff_s;
    logic signed [E_W-1:0] span_k;
    logic signed [E_W-1:0] e_s;
    logic [PROD_W:0]       e_mag;
    assign low_mv = PROD_W'(cal_temp_low_reg) * PROD_W'(stmcd_pkg::CAL_MV);
    assign diff_s = $signed({1'b0, prod_reg}) - $signed({1'b0, low_mv});
    assign span_k = $signed(E_W'(span_s)) * $signed(E_W'(stmcd_pkg::OFFSET_K));
    assign e_s    = $signed(E_W'(diff_s)) + span_k;
    assign e_mag  = e_s[E_W-1] ? (PROD_W+1)'(-e_s) : (PROD_W+1)'(e_s);

    // Divider step: bring down one dividend bit, subtract when it fits
    logic [DEN_W:0] part;
    logic [DEN_W:0] trial;
    logic           take;
    assign part  = {rem_reg, num_reg[QUO_W-1]};
    assign trial = part - {1'b0, den_reg};
    assign take  = part >= {1'b0, den_reg};

    // Saturated supply reading and its tens digit group
    logic [MV_W-1:0] mv_w;
    logic [31:0]     mv10_prod;
    assign mv_w      = ovf_reg ? {MV_W{1'b1}} : quo_reg;
    assign mv10_prod = 32'(mv_w) * 32'(stmcd_pkg::DIV10_MUL);

    // Signed, saturated temperature from the quotient magnitude
    logic signed [TEMP_W-1:0] temp_w;
    always_comb begin
        if (neg_reg) begin
            if (ovf_reg || (quo_reg > QUO_W'(-stmcd_pkg::TEMP_MIN))) begin
                temp_w = TEMP_W'(stmcd_pkg::TEMP_MIN);
            end else begin
                temp_w = TEMP_W'(-$signed({1'b0, quo_reg}));
            end
        end else begin
            if (ovf_reg || (quo_reg > QUO_W'(stmcd_pkg::TEMP_MAX))) begin
                temp_w = TEMP_W'(stmcd_pkg::TEMP_MAX);
            end else begin
                temp_w = TEMP_W'(quo_reg);
            end
        end
    end

    // Change detection against the values last recorded as sent
    logic signed [MV_W:0]   dv_s;
    logic [MV_W-1:0]        dv_mag;
    logic signed [TEMP_W:0] dt_s;
    logic [TEMP_W-1:0]      dt_mag;
    logic [VTHR_W-1:0]      thr_v;
    logic [TTHR_W-1:0]      thr_t;
    logic                   send_w;
    assign dv_s   = $signed({1'b0, acc_reg}) - $signed({1'b0, sent_supply_reg});
    assign dv_mag = dv_s[MV_W] ? MV_W'(-dv_s) : MV_W'(dv_s);
    assign dt_s   = $signed({cur_temp_reg[TEMP_W-1], cur_temp_reg})
                  - $signed({sent_temp_reg[TEMP_W-1], sent_temp_reg});
    assign dt_mag = dt_s[TEMP_W] ? TEMP_W'(-dt_s) : TEMP_W'(dt_s);
    assign thr_v  = VTHR_W'(min_pct_supply_reg) * VTHR_W'(stmcd_pkg::SUPPLY_STEP);
    assign thr_t  = TTHR_W'(min_pct_temp_reg) * TTHR_W'(stmcd_pkg::TEMP_STEP);
    assign send_w = (dv_mag >= MV_W'(thr_v)) || (dt_mag >= TEMP_W'(thr_t));

    // Sequencer, datapath, monitor state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_tvalid_reg       <= 1'b0;
            last_reg           <= '0;
            last10_reg         <= '0;
            acc_reg            <= '0;
            cur_temp_reg       <= '0;
            sent_supply_reg    <= '0;
            sent_temp_reg      <= '0;
            cal_vref_reg       <= stmcd_pkg::CAL_VREF_RST;
            cal_temp_low_reg   <= stmcd_pkg::CAL_TEMP_LOW_RST;
            cal_temp_high_reg  <= stmcd_pkg::CAL_TEMP_HIGH_RST;
            min_pct_supply_reg <= stmcd_pkg::MIN_PCT_SUPPLY_RST;
            min_pct_temp_reg   <= stmcd_pkg::MIN_PCT_TEMP_RST;
        end else begin
            // drop the result once taken, unless a new one replaces it now
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_valid && cfg_ready) begin
                case (stmcd_pkg::cfg_reg_t'(cfg_index))
                    stmcd_pkg::REG_CAL_VREF:       cal_vref_reg       <= cfg_data[CAL_W-1:0];
                    stmcd_pkg::REG_CAL_TEMP_LOW:   cal_temp_low_reg   <= cfg_data[CAL_W-1:0];
                    stmcd_pkg::REG_CAL_TEMP_HIGH:  cal_temp_high_reg  <= cfg_data[CAL_W-1:0];
                    stmcd_pkg::REG_MIN_PCT_SUPPLY: min_pct_supply_reg <= cfg_data[PCT_W-1:0];
                    stmcd_pkg::REG_MIN_PCT_TEMP:   min_pct_temp_reg   <= cfg_data[PCT_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        op_reg  <= s_opcode;
                        smp_reg <= s_sample;
                        case (s_opcode)
                            stmcd_pkg::OP_REFERENCE: begin
                                if (s_sample == '0) begin
                                    // zero sample saturates the reading
                                    ovf_reg   <= 1'b1;
                                    state_reg <= ST_SCALE;
                                end else begin
                                    num_reg   <= NUM_W'(vref_num);
                                    den_reg   <= DEN_W'(s_sample);
                                    state_reg <= ST_DINIT;
                                end
                            end
                            stmcd_pkg::OP_TEMPERATURE: begin
                                if (span_s == '0) begin
                                    // flat calibration reads as the low point
                                    temp_reg  <= TEMP_W'(stmcd_pkg::TEMP_MID);
                                    state_reg <= ST_COMMIT;
                                end else begin
                                    prod_reg  <= '0;
                                    cnt_reg   <= '0;
                                    state_reg <= ST_MUL;
                                end
                            end
                            default: begin
                                state_reg <= ST_COMMIT;
                            end
                        endcase
                    end
                end

                // sample times accepted supply, one sample bit per cycle, MSB first
                ST_MUL: begin
                    prod_reg <= {prod_reg[PROD_W-2:0], 1'b0}
                              + (smp_reg[ADC_BITS-1] ? PROD_W'(acc_reg) : PROD_W'(0));
                    smp_reg  <= {smp_reg[ADC_BITS-2:0], 1'b0};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ADC_BITS - 1)) begin
                        state_reg <= ST_PREP;
                    end
                end

                // offset, sign and divisor of the interpolation
                ST_PREP: begin
                    num_reg   <= NUM_W'(e_mag);
                    neg_reg   <= e_s[E_W-1] ^ span_s[CAL_W];
                    den_reg   <= DEN_W'(span_mag) * DEN_W'(stmcd_pkg::CAL_MV);
                    state_reg <= ST_NSCL;
                end

                // scale the numerator by 1000 as 1024 - 16 - 8
                ST_NSCL: begin
                    num_reg   <= (num_reg << 10) - (num_reg << 4) - (num_reg << 3);
                    state_reg <= ST_DINIT;
                end

                // catch quotients too wide for the divider, else load the remainder
                ST_DINIT: begin
                    cnt_reg <= '0;
                    quo_reg <= '0;
                    if (num_reg >= {den_reg, {QUO_W{1'b0}}}) begin
                        ovf_reg   <= 1'b1;
                        state_reg <= ST_SCALE;
                    end else begin
                        ovf_reg   <= 1'b0;
                        rem_reg   <= num_reg[NUM_W-1:QUO_W];
                        state_reg <= ST_DIV;
                    end
                end

                // one quotient bit per cycle
                ST_DIV: begin
                    rem_reg <= take ? trial[DEN_W-1:0] : part[DEN_W-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], take};
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                        state_reg <= ST_SCALE;
                    end
                end

                // saturate into millivolts or tenths of a degree
                ST_SCALE: begin
                    mv_reg    <= mv_w;
                    mv10_reg  <= mv10_prod[stmcd_pkg::DIV10_SHIFT +: MV10_W];
                    temp_reg  <= temp_w;
                    state_reg <= ST_COMMIT;
                end

                // update the monitor state
                ST_COMMIT: begin
                    stable_reg <= (op_reg == stmcd_pkg::OP_REFERENCE)
                               && (mv10_reg == last10_reg);
                    case (op_reg)
                        stmcd_pkg::OP_REFERENCE: begin
                            if (mv10_reg == last10_reg) begin
                                acc_reg <= last_reg;
                            end
                            last_reg   <= mv_reg;
                            last10_reg <= mv10_reg;
                        end
                        stmcd_pkg::OP_TEMPERATURE: begin
                            cur_temp_reg <= temp_reg;
                        end
                        stmcd_pkg::OP_RECORD: begin
                            sent_supply_reg <= acc_reg;
                            sent_temp_reg   <= cur_temp_reg;
                        end
                        default: ;
                    endcase
                    state_reg <= ST_OUT;
                end

                // hold until the output register is free, then load the result beat
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_supply_reg <= (op_reg == stmcd_pkg::OP_REFERENCE) ? mv_reg : acc_reg;
                        m_temp_reg   <= cur_temp_reg;
                        m_stable_reg <= stable_reg;
                        m_send_reg   <= send_w;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_temp_reg, m_supply_reg};
    assign m_tuser  = {m_send_reg, m_stable_reg};

    // an accepted beat leaves the idle step at once
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready after a beat was accepted");

    // restoring divider keeps its remainder below the divisor
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    // a stable reading promotes the previous reading to the accepted supply
    a_stable_promotes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT) && (op_reg == stmcd_pkg::OP_REFERENCE)
            && (mv10_reg == last10_reg)
        |=> (acc_reg == $past(last_reg)) && stable_reg)
        else $error("stable reading did not update the accepted supply");

    // current temperature stays inside the saturation range
    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_temp_reg >= TEMP_W'(stmcd_pkg::TEMP_MIN))
            && (cur_temp_reg <= TEMP_W'(stmcd_pkg::TEMP_MAX)))
        else $error("temperature outside the saturation range");

endmodule

`default_nettype wire

### tb/stmcd_result_check.sv
`timescale 1ns / 100ps
// Result checker for the supply and temperature monitor core.
// Watches the input, result and register channels, predicts every result and compares it.
// Depends on stmcd_pkg.

module stmcd_result_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [11:0] sample
    input  logic [1:0]  s_tuser,    // [1:0] opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [15:0] supply_mv, [27:16] temp_tenths
    input  logic [1:0]  m_tuser,    // [0] stable, [1] send_needed
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output int          fail_count,
    output int          results_pending
);

    typedef struct packed {
        logic [stmcd_pkg::MV_W-1:0]   supply;
        logic [stmcd_pkg::TEMP_W-1:0] temp;
        logic                         stable;
        logic                         send;
    } monitor_result_t;

    // Calibration and threshold registers as the core should hold them
    logic [stmcd_pkg::CAL_W-1:0] vref_cal, low_cal, high_cal;
    logic [stmcd_pkg::PCT_W-1:0] supply_pct, temp_pct;

    // Monitor state
    logic [stmcd_pkg::MV_W-1:0] prev_reading_mv, accepted_mv, sent_mv;
    int                         temp_now, temp_sent;

    monitor_result_t due_results[$];
    int              fails = 0;
    int              pending = 0;
    int              beats_seen = 0;

    assign fail_count      = fails;
    assign results_pending = pending;

    // Advance the monitor state by one input beat and return the result it should produce
    function automatic monitor_result_t step_monitor(
        input stmcd_pkg::opcode_t op,
        input logic [stmcd_pkg::SAMPLE_W-1:0] s);
        longint                     q, span, den, num, t, dv, dt;
        logic [stmcd_pkg::MV_W-1:0] reading;
        monitor_result_t            r;
        r.supply = accepted_mv;
        r.stable = 1'b0;
        case (op)
            stmcd_pkg::OP_REFERENCE: begin
                // Zero sample or oversized quotient saturate the reading
                if (s == 0) begin
                    reading = 16'hFFFF;
                end else begin
                    q = (longint'(stmcd_pkg::CAL_MV) * longint'(vref_cal)) / longint'(s);
                    reading = (q > 65535) ? 16'hFFFF : q[15:0];
                end
                if (reading / 10 == prev_reading_mv / 10) begin
                    r.stable    = 1'b1;
                    accepted_mv = prev_reading_mv;
                end
                prev_reading_mv = reading;
                r.supply        = reading;
            end
            stmcd_pkg::OP_TEMPERATURE: begin
                span = longint'(high_cal) - longint'(low_cal);
                if (span == 0) begin
                    temp_now = stmcd_pkg::TEMP_MID;
                end else begin
                    // Rescale to the calibration supply, interpolate, truncate toward zero
                    den = longint'(stmcd_pkg::CAL_MV) * span;
                    num = (longint'(s) * longint'(accepted_mv)
                           - longint'(low_cal) * longint'(stmcd_pkg::CAL_MV)) * 1000
                          + longint'(stmcd_pkg::TEMP_MID) * den;
                    if (den < 0) begin
                        den = -den;
                        num = -num;
                    end
                    t = num / den;
                    if (t < stmcd_pkg::TEMP_MIN) t = stmcd_pkg::TEMP_MIN;
                    if (t > stmcd_pkg::TEMP_MAX) t = stmcd_pkg::TEMP_MAX;
                    temp_now = int'(t);
                end
            end
            stmcd_pkg::OP_RECORD: begin
                sent_mv   = accepted_mv;
                temp_sent = temp_now;
            end
            default: ;
        endcase
        r.temp = temp_now[stmcd_pkg::TEMP_W-1:0];
        dv = longint'(accepted_mv) - longint'(sent_mv);
        dt = longint'(temp_now) - longint'(temp_sent);
        if (dv < 0) dv = -dv;
        if (dt < 0) dt = -dt;
        r.send = (dv >= longint'(supply_pct) * stmcd_pkg::SUPPLY_STEP)
              || (dt >= longint'(temp_pct) * stmcd_pkg::TEMP_STEP);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fails++;
        if (fails <= 40)
            $display("%0t ns: result beat %0d, %s: got %0d, want %0d",
                     $time, beats_seen, what, got, want);
    endtask

    // Track register writes, check result beats, queue predictions for input beats
    always @(posedge aclk) begin
        monitor_result_t due;
        if (!aresetn) begin
            vref_cal        = stmcd_pkg::CAL_VREF_RST;
            low_cal         = stmcd_pkg::CAL_TEMP_LOW_RST;
            high_cal        = stmcd_pkg::CAL_TEMP_HIGH_RST;
            supply_pct      = stmcd_pkg::MIN_PCT_SUPPLY_RST;
            temp_pct        = stmcd_pkg::MIN_PCT_TEMP_RST;
            prev_reading_mv = '0;
            accepted_mv     = '0;
            sent_mv         = '0;
            temp_now        = 0;
            temp_sent       = 0;
            due_results.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (stmcd_pkg::cfg_reg_t'(cfg_index))
                    stmcd_pkg::REG_CAL_VREF:
                        vref_cal   = cfg_data[stmcd_pkg::CAL_W-1:0];
                    stmcd_pkg::REG_CAL_TEMP_LOW:
                        low_cal    = cfg_data[stmcd_pkg::CAL_W-1:0];
                    stmcd_pkg::REG_CAL_TEMP_HIGH:
                        high_cal   = cfg_data[stmcd_pkg::CAL_W-1:0];
                    stmcd_pkg::REG_MIN_PCT_SUPPLY:
                        supply_pct = cfg_data[stmcd_pkg::PCT_W-1:0];
                    stmcd_pkg::REG_MIN_PCT_TEMP:
                        temp_pct   = cfg_data[stmcd_pkg::PCT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing pending", m_tdata[15:0], 0);
                end else begin
                    due = due_results.pop_front();
                    if (m_tdata[15:0] !== due.supply)
                        report_mismatch("supply_mv", m_tdata[15:0], due.supply);
                    if (m_tdata[27:16] !== due.temp)
                        report_mismatch("temp_tenths", $signed(m_tdata[27:16]),
                                        $signed(due.temp));
                    if (m_tuser[0] !== due.stable)
                        report_mismatch("stable", m_tuser[0], due.stable);
                    if (m_tuser[1] !== due.send)
                        report_mismatch("send_needed", m_tuser[1], due.send);
                end
                beats_seen++;
            end
            if (s_tvalid && s_tready)
                due_results.push_back(step_monitor(stmcd_pkg::opcode_t'(s_tuser),
                                                   s_tdata[stmcd_pkg::SAMPLE_W-1:0]));
            pending <= due_results.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the monitor core testbench: clock, reset, stimulus, back-pressure and verdict.
// Depends on stmcd_pkg, supply_temp_monitor_change_detect_core and stmcd_result_check.

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;    // [11:0] sample
    logic [1:0]  s_tuser   = '0;    // [1:0] opcode
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [31:0] m_tdata;      // [15:0] supply_mv, [27:16] temp_tenths
    wire logic [1:0]  m_tuser;      // [0] stable, [1] send_needed
    wire logic        cfg_ready;
    int fail_count;
    int results_pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles         = 0;

    // Calibration currently loaded, used to aim samples at interesting ranges
    int          cur_vref = stmcd_pkg::CAL_VREF_RST;
    int          cur_low  = stmcd_pkg::CAL_TEMP_LOW_RST;
    int          cur_high = stmcd_pkg::CAL_TEMP_HIGH_RST;
    logic [11:0] ref_base = 12'd1655;

    always #5 aclk = ~aclk;

    supply_temp_monitor_change_detect_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stmcd_result_check result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Guard against a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_sample(input stmcd_pkg::opcode_t op, input logic [11:0] s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, s};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the input until every predicted result has come out, then let the core settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input stmcd_pkg::cfg_reg_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[11:0];
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write all five registers back to back; only call while the core is idle
    task automatic load_config(input int vref, input int lo, input int hi,
                               input int pct_v, input int pct_t);
        write_reg(stmcd_pkg::REG_CAL_VREF, vref);
        write_reg(stmcd_pkg::REG_CAL_TEMP_LOW, lo);
        write_reg(stmcd_pkg::REG_CAL_TEMP_HIGH, hi);
        write_reg(stmcd_pkg::REG_MIN_PCT_SUPPLY, pct_v);
        write_reg(stmcd_pkg::REG_MIN_PCT_TEMP, pct_t);
        cfg_valid <= 1'b0;
        cur_vref = vref;
        cur_low  = lo;
        cur_high = hi;
        @(posedge aclk);
    endtask

    // Pick a sample near the calibration window, with some fully random noise
    function automatic logic [11:0] temp_sample();
        int a, b;
        a = (cur_low < cur_high ? cur_low : cur_high) - 300;
        b = (cur_low < cur_high ? cur_high : cur_low) + 300;
        if (a < 0) a = 0;
        if (b > 4095) b = 4095;
        if ($urandom_range(0, 99) < 15) return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(a, b));
    endfunction

    // Random items: mostly reference pairs that can settle, temperatures and records
    task automatic run_phase(input int n_items);
        int done, kind, target_mv, base;
        done = 0;
        while (done < n_items) begin
            if (done % 8 == 0) begin
                target_mv = $urandom_range(1800, 3600);
                base = (cur_vref == 0) ? $urandom_range(1, 4095) : cur_vref * 3000 / target_mv;
                ref_base = (base > 4095) ? 12'd4095 : base[11:0];
            end
            if ($urandom_range(0, 149) == 0)
                drain_results();
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                send_sample(stmcd_pkg::OP_REFERENCE, 12'(ref_base + $urandom_range(0, 2)));
                send_sample(stmcd_pkg::OP_REFERENCE, 12'(ref_base + $urandom_range(0, 2)));
                done += 2;
            end else if (kind < 70) begin
                send_sample(stmcd_pkg::OP_TEMPERATURE, temp_sample());
                done++;
            end else if (kind < 82) begin
                send_sample(stmcd_pkg::OP_RECORD, 12'($urandom_range(0, 4095)));
                done++;
            end else if (kind < 87) begin
                send_sample(stmcd_pkg::OP_HOLD, 12'($urandom_range(0, 4095)));
                done++;
            end else begin
                send_sample(stmcd_pkg::opcode_t'($urandom_range(0, 3)),
                            12'($urandom_range(0, 4095)));
                done++;
            end
        end
    endtask

    function automatic int rand_pct();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 100;
        return $urandom_range(1, 20);
    endfunction

    initial begin
        int mode;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: saturation, first reference after reset, settling, calibration points
        send_sample(stmcd_pkg::OP_REFERENCE, 12'd0);
        send_sample(stmcd_pkg::OP_REFERENCE, 12'd0);
        send_sample(stmcd_pkg::OP_TEMPERATURE, 12'd4095);
        send_sample(stmcd_pkg::OP_TEMPERATURE, 12'd0);
        send_sample(stmcd_pkg::OP_RECORD, 12'd0);
        send_sample(stmcd_pkg::OP_HOLD, 12'd4095);
        send_sample(stmcd_pkg::OP_REFERENCE, 12'd1);
        send_sample(stmcd_pkg::OP_REFERENCE, 12'd4095);
        send_sample(stmcd_pkg::OP_REFERENCE, 12'd4095);
        send_sample(stmcd_pkg::OP_REFERENCE, 12'd1655);
        send_sample(stmcd_pkg::OP_REFERENCE, 12'd1655);
        send_sample(stmcd_pkg::OP_TEMPERATURE, 12'd1030);
        send_sample(stmcd_pkg::OP_TEMPERATURE, 12'd1370);
        send_sample(stmcd_pkg::OP_RECORD, 12'd4095);
        send_sample(stmcd_pkg::OP_TEMPERATURE, 12'd1200);
        send_sample(stmcd_pkg::OP_HOLD, 12'd0);
        send_sample(stmcd_pkg::OP_REFERENCE, 12'd1650);
        send_sample(stmcd_pkg::OP_REFERENCE, 12'd1660);
        send_sample(stmcd_pkg::OP_REFERENCE, 12'd1656);
        send_sample(stmcd_pkg::OP_TEMPERATURE, 12'd1030);
        send_sample(stmcd_pkg::OP_RECORD, 12'd0);
        send_sample(stmcd_pkg::OP_TEMPERATURE, 12'd2730);
        drain_results();

        // Fixed settings: defaults, wide extremes, zero span, inverted span
        load_config(1655, 1030, 1370, 1, 10);
        run_phase(130);
        drain_results();
        load_config(4095, 0, 4095, 0, 0);
        send_idle_pct = 65;
        run_phase(130);
        drain_results();
        load_config(0, 2000, 2000, 100, 100);
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        run_phase(130);
        drain_results();
        load_config(1200, 1370, 1030, 5, 3);
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        run_phase(130);

        // Random settings, cycling through the idle patterns
        for (mode = 0; mode < 4; mode++) begin
            drain_results();
            load_config($urandom_range(0, 9) == 0 ? 4095 : $urandom_range(900, 2400),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        rand_pct(), rand_pct());
            send_idle_pct  = (mode == 1) ? 65 : (mode == 3) ? 17 : 0;
            recv_stall_pct = (mode == 2) ? 65 : (mode == 3) ? 17 : 0;
            run_phase(130);
        end

        drain_results();
        load_config(1655, 1030, 1370, 1, 10);
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        run_phase(60);

        drain_results();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
